[src/chfc_pkg.sv]
// chfc_pkg: shared widths, symbol table and helper functions for the
// character frequency counter; no dependencies
`default_nettype none

package chfc_pkg;

  localparam int TABLE_SIZE  = 60;
  localparam int IDX_W       = $clog2(TABLE_SIZE);
  localparam int COUNT_WIDTH = 24;
  localparam int OCC_W       = 24;
  localparam int BYTE_W      = 8;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [31:0]            OCC_MAX   = 32'((64'd1 << OCC_W) - 64'd1);
  localparam logic [IDX_W-1:0]       LAST_IDX  = IDX_W'(TABLE_SIZE - 1);

  // symbol table in report order
  localparam logic [BYTE_W-1:0] SYM_TABLE [TABLE_SIZE] = '{
    "a", "A", "b", "B", "c", "C", "d", "D", "e", "E", "f", "F", "g", "G", "h", "H",
    "i", "I", "j", "J", "k", "K", "l", "L", "m", "M", "n", "N", "o", "O", "p", "P",
    "q", "Q", "r", "R", "s", "S", "T", "t", "u", "v", "V", "w", "W", "x", "X", "y",
    "Y", "z", "Z", ",", ";", ".", ":", "-", "_", "\"", "!", " "
  };

  // controller to datapath
  typedef struct packed {
    logic load_byte;   // capture byte, read its counter
    logic upd_write;   // write back incremented counter
    logic scan_read;   // read counter at scan index
    logic scan_emit;   // load result register from scan entry
    logic scan_adv;    // drop scan entry, step scan index
  } chfc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic end_flag;    // captured byte closes the text
    logic scan_valid;  // scan entry holds a nonzero count
    logic scan_at_end; // scan index on the final table entry
    logic out_free;    // result register can take a new result
  } chfc_stat_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } chfc_match_t;

  // table entries are distinct, so at most one compare fires
  function automatic chfc_match_t byte_match(logic [BYTE_W-1:0] b);
    chfc_match_t m;
    m.hit = 1'b0;
    m.idx = '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (SYM_TABLE[i] == b) begin
        m.hit = 1'b1;
        m.idx = IDX_W'(i);
      end
    end
    return m;
  endfunction

  // clamp a counter to the occurrences field
  function automatic logic [OCC_W-1:0] occ_sat(logic [COUNT_WIDTH-1:0] c);
    logic [31:0] wide;
    wide = 32'(c);
    if (wide > OCC_MAX) begin
      wide = OCC_MAX;
    end
    return wide[OCC_W-1:0];
  endfunction

endpackage

`default_nettype wire

[src/chfc_if.sv]
// chfc_in_if / chfc_out_if: valid-ready channels of the character
// frequency counter; depends on chfc_pkg
`default_nettype none

interface chfc_in_if import chfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface chfc_out_if import chfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] symbol_code;
  logic [OCC_W-1:0]  occurrences;
  logic              last_symbol;

  modport source (output valid, output symbol_code, output occurrences,
                  output last_symbol, input ready);
  modport sink   (input valid, input symbol_code, input occurrences,
                  input last_symbol, output ready);
endinterface

`default_nettype wire

[src/chfc_ctrl.sv]
// chfc_ctrl: sequencing state machine for byte update and report scan
// depends on chfc_pkg
`default_nettype none

module chfc_ctrl import chfc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire chfc_stat_t stat,
  output chfc_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_UPD      = 2'd1;
  localparam logic [1:0] S_SCAN_RD  = 2'd2;
  localparam logic [1:0] S_SCAN_OUT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_byte = 1'b1;
          state_nxt     = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd_write = 1'b1;
        state_nxt     = stat.end_flag ? S_SCAN_RD : S_IDLE;
      end
      S_SCAN_RD: begin
        cmd.scan_read = 1'b1;
        state_nxt     = S_SCAN_OUT;
      end
      S_SCAN_OUT: begin
        // empty entries pass at once, full ones wait for the result register
        if (!stat.scan_valid || stat.out_free) begin
          cmd.scan_emit = stat.scan_valid;
          cmd.scan_adv  = 1'b1;
          state_nxt     = stat.scan_at_end ? S_IDLE : S_SCAN_RD;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[src/chfc_datapath.sv]
// chfc_datapath: counter memory with valid bits, byte match, scan index
// and result register; depends on chfc_pkg
`default_nettype none

module chfc_datapath import chfc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire chfc_cmd_t         cmd,
  output chfc_stat_t             stat,
  input  wire logic [BYTE_W-1:0] in_text_byte,
  input  wire logic              in_end_of_text,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_symbol_code,
  output logic [OCC_W-1:0]       out_occurrences,
  output logic                   out_last_symbol
);

  logic [COUNT_WIDTH-1:0] mem [TABLE_SIZE];
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic [TABLE_SIZE-1:0]  valid_r;
  logic [TABLE_SIZE-1:0]  valid_nxt;

  logic [IDX_W-1:0] idx_r;
  logic             hit_r;
  logic             end_r;
  logic [IDX_W-1:0] scan_idx_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] sym_r;
  logic [OCC_W-1:0]  occ_r;
  logic              last_r;

  chfc_match_t            match;
  logic [IDX_W-1:0]       rd_addr;
  logic                   rd_en;
  logic                   wr_en;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic [TABLE_SIZE-1:0]  above;
  logic                   scan_last;
  logic                   out_free;

  assign match   = byte_match(in_text_byte);
  assign rd_en   = cmd.load_byte | cmd.scan_read;
  assign rd_addr = cmd.load_byte ? match.idx : scan_idx_r;
  assign wr_en   = cmd.upd_write & hit_r;

  // an entry without its valid bit counts as zero
  always_comb begin
    if (!valid_r[idx_r]) begin
      wr_data = COUNT_WIDTH'(1);
    end else if (rd_data_r == COUNT_MAX) begin
      wr_data = rd_data_r;
    end else begin
      wr_data = rd_data_r + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // a valid entry always holds a nonzero count
  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt[idx_r] = 1'b1;
    end
    if (cmd.scan_adv) begin
      valid_nxt[scan_idx_r] = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      above[i] = (IDX_W'(i) > scan_idx_r);
    end
  end

  assign scan_last = ~|(valid_r & above);
  assign out_free  = ~out_valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (cmd.scan_adv) begin
        scan_idx_r <= (scan_idx_r == LAST_IDX) ? '0 : scan_idx_r + IDX_W'(1);
      end
      if (cmd.scan_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      idx_r <= match.idx;
      hit_r <= match.hit;
      end_r <= in_end_of_text;
    end
    if (cmd.scan_emit) begin
      sym_r  <= SYM_TABLE[scan_idx_r];
      occ_r  <= occ_sat(rd_data_r);
      last_r <= scan_last;
    end
  end

  assign stat.end_flag    = end_r;
  assign stat.scan_valid  = valid_r[scan_idx_r];
  assign stat.scan_at_end = (scan_idx_r == LAST_IDX);
  assign stat.out_free    = out_free;

  assign out_valid       = out_valid_r;
  assign out_symbol_code = sym_r;
  assign out_occurrences = occ_r;
  assign out_last_symbol = last_r;

endmodule

`default_nettype wire

[src/character_frequency_counter_core.sv]
// character_frequency_counter_core: top level of the character histogram
// depends on chfc_pkg, chfc_if, chfc_ctrl, chfc_datapath
`default_nettype none

// channel   dir  transaction        payload
// in_chan   in   one text byte      text_byte[7:0], end_of_text
// out_chan  out  one table symbol   symbol_code[7:0], occurrences[23:0], last_symbol
//
// a plain byte takes a counter read from the memory port, then a write back
// an end-of-text byte adds a report scan of every table entry, a read then an emit each,
// plus any wait for out_chan.ready on full entries
// in_chan.ready is low from acceptance until the byte and any report are done
// a result waits in the output register while the next byte is taken
// synchronous reset clears all counts through per-entry valid bits, no sweep

module character_frequency_counter_core import chfc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  chfc_in_if.sink     in_chan,
  chfc_out_if.source  out_chan
);

  chfc_cmd_t  cmd;
  chfc_stat_t stat;

  // sequencer: idle, counter update, scan read, scan emit
  chfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // counter memory, match logic and result register
  chfc_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_text_byte    (in_chan.text_byte),
    .in_end_of_text  (in_chan.end_of_text),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_symbol_code (out_chan.symbol_code),
    .out_occurrences (out_chan.occurrences),
    .out_last_symbol (out_chan.last_symbol)
  );

endmodule

`default_nettype wire
